[rtl/tsc_pkg.sv]
// Package for the touch swipe classifier.
// Holds gesture codes, field widths and the record passed between the two stages.
// No dependencies.
package tsc_pkg;

    localparam int COORD_W = 12;
    localparam int RANGE_W = 12;
    localparam int SLOPE_W = 16;
    localparam int GEST_W  = 4;
    localparam int PROD_W  = SLOPE_W + COORD_W;

    localparam logic [GEST_W-1:0] G_NONE       = 4'd0;
    localparam logic [GEST_W-1:0] G_CLICK      = 4'd1;
    localparam logic [GEST_W-1:0] G_LEFT       = 4'd2;
    localparam logic [GEST_W-1:0] G_RIGHT      = 4'd4;
    localparam logic [GEST_W-1:0] G_UP         = 4'd6;
    localparam logic [GEST_W-1:0] G_DOWN       = 4'd8;
    localparam logic [GEST_W-1:0] G_MAYBE_DOWN = 4'd9;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 1'd1;

    localparam logic [RANGE_W-1:0] TAP_ZONE_RST = 12'd40;
    localparam logic [SLOPE_W-1:0] SLOPE_RST    = 16'd640;

    // Front-stage record: release edge flag, delta magnitudes and signs, echoed point.
    typedef struct packed {
        logic               release_edge;
        logic               dx_neg;
        logic               dy_neg;
        logic [COORD_W-1:0] adx;
        logic [COORD_W-1:0] ady;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_s1;

endpackage

[rtl/tsc_front.sv]
// Front stage of the touch swipe classifier: pen edge tracking, start point latch
// and delta magnitudes, registered. Depends on tsc_pkg.
module tsc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_touched,
    input  logic [tsc_pkg::COORD_W-1:0] i_px,
    input  logic [tsc_pkg::COORD_W-1:0] i_py,
    input  logic                        i_take,
    output logic                        o_valid,
    output tsc_pkg::t_s1                o_s1
);

    logic                        r_was_down;
    logic [tsc_pkg::COORD_W-1:0] r_start_x;
    logic [tsc_pkg::COORD_W-1:0] r_start_y;
    logic                        r_valid;
    tsc_pkg::t_s1                r_s1;
    tsc_pkg::t_s1                n_s1;

    always_comb begin
        n_s1.release_edge = !i_touched && r_was_down;
        n_s1.dx_neg       = r_start_x < i_px;
        n_s1.dy_neg       = r_start_y < i_py;
        n_s1.adx          = n_s1.dx_neg ? (i_px - r_start_x) : (r_start_x - i_px);
        n_s1.ady          = n_s1.dy_neg ? (i_py - r_start_y) : (r_start_y - i_py);
        n_s1.px           = i_px;
        n_s1.py           = i_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_accept) begin
                r_was_down <= i_touched;
                // Pen-down edge latches the start point.
                if (i_touched && !r_was_down) begin
                    r_start_x <= i_px;
                    r_start_y <= i_py;
                end
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

[rtl/tsc_decide.sv]
// Decision stage of the touch swipe classifier: click test, dominant axis, slope
// test and the result register. Depends on tsc_pkg.
module tsc_decide (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tsc_pkg::t_s1                i_s1,
    input  logic [tsc_pkg::RANGE_W-1:0] i_tap_zone,
    input  logic [tsc_pkg::SLOPE_W-1:0] i_slope,
    input  logic                        i_m_ready,
    output logic                        o_take,
    output logic                        o_valid,
    output logic [tsc_pkg::GEST_W-1:0]  o_gesture,
    output logic [tsc_pkg::COORD_W-1:0] o_x,
    output logic [tsc_pkg::COORD_W-1:0] o_y
);

    logic                        r_valid;
    logic [tsc_pkg::GEST_W-1:0]  r_gesture;
    logic [tsc_pkg::COORD_W-1:0] r_x;
    logic [tsc_pkg::COORD_W-1:0] r_y;
    logic [tsc_pkg::GEST_W-1:0]  n_gesture;
    logic                        w_free;
    logic                        w_horiz;
    logic                        w_neg;
    logic                        w_sure;
    logic [tsc_pkg::COORD_W-1:0] w_major;
    logic [tsc_pkg::COORD_W-1:0] w_minor;
    logic [tsc_pkg::PROD_W-1:0]  w_lhs;
    logic [tsc_pkg::PROD_W-1:0]  w_rhs;
    logic [tsc_pkg::GEST_W-1:0]  w_base;

    assign w_free = !r_valid || i_m_ready;
    assign o_take = i_valid && w_free;

    always_comb begin
        // Equal magnitudes fall to the vertical axis.
        w_horiz = i_s1.adx > i_s1.ady;
        w_major = w_horiz ? i_s1.adx : i_s1.ady;
        w_minor = w_horiz ? i_s1.ady : i_s1.adx;
        w_neg   = w_horiz ? i_s1.dx_neg : i_s1.dy_neg;
        // Ratio test without a divider: major * 256 against slope * minor.
        w_lhs   = {{(tsc_pkg::PROD_W - tsc_pkg::COORD_W - 8){1'b0}}, w_major, 8'd0};
        w_rhs   = {{tsc_pkg::COORD_W{1'b0}}, i_slope}
                * {{tsc_pkg::SLOPE_W{1'b0}}, w_minor};
        w_sure  = w_lhs > w_rhs;
        if (w_horiz) begin
            w_base = w_neg ? tsc_pkg::G_LEFT : tsc_pkg::G_RIGHT;
        end else begin
            w_base = w_neg ? tsc_pkg::G_UP : tsc_pkg::G_DOWN;
        end
        if (!i_s1.release_edge) begin
            n_gesture = tsc_pkg::G_NONE;
        end else if (i_s1.adx < i_tap_zone && i_s1.ady < i_tap_zone) begin
            n_gesture = tsc_pkg::G_CLICK;
        end else begin
            n_gesture = w_base + {{(tsc_pkg::GEST_W-1){1'b0}}, !w_sure};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_gesture <= n_gesture;
            r_x       <= i_s1.px;
            r_y       <= i_s1.py;
        end
    end

    assign o_valid   = r_valid;
    assign o_gesture = r_gesture;
    assign o_x       = r_x;
    assign o_y       = r_y;

endmodule

[rtl/touch_swipe_classifier.sv]
// An input transfer passes through the front register and then the result register.
// Throughput: one poll per cycle while m_axis_tready is high; the front register and
// the result register form a two-deep pipeline, so a poll is still taken while a finished result waits.
// Reset (i_rst_n low, synchronous): pipeline empty, pen up, start point (0,0),
// click zone 40 and slope 640 (2.5 in Q8.8).
module touch_swipe_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port: index 0 click zone, index 1 slope_q8_8.
    input  logic        i_cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsc_pkg::SLOPE_W-1:0]   i_cfg_wdata,
    // Poll input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] point_x, [23:12] point_y
    input  logic        s_axis_tuser,   // [0] pen_touched
    // Gesture output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [3:0] gesture, [15:4] last_x, [27:16] last_y,
                                        // [31:28] zero
);

    logic [tsc_pkg::RANGE_W-1:0] r_tap_zone;
    logic [tsc_pkg::SLOPE_W-1:0] r_slope;

    logic                        w_accept;
    logic                        w_s1_valid;
    logic                        w_take;
    tsc_pkg::t_s1                w_s1;
    logic [tsc_pkg::GEST_W-1:0]  w_gesture;
    logic [tsc_pkg::COORD_W-1:0] w_x;
    logic [tsc_pkg::COORD_W-1:0] w_y;

    // Configuration registers. The user must write them only while the pipeline is idle
    // (the block itself does not enforce this), so both stages can read them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_zone <= tsc_pkg::TAP_ZONE_RST;
            r_slope    <= tsc_pkg::SLOPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsc_pkg::CFG_TAP_ZONE: r_tap_zone <= i_cfg_wdata[tsc_pkg::RANGE_W-1:0];
                tsc_pkg::CFG_SLOPE:    r_slope    <= i_cfg_wdata;
                default:               r_slope    <= r_slope;
            endcase
        end
    end

    // The front register can take a poll when it is empty or is handing its
    // content to the result register in the same cycle.
    assign s_axis_tready = !w_s1_valid || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Edge tracking and start point latch act at the input transfer itself, so the
    // next poll sees the updated state with no bubble.
    tsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_touched (s_axis_tuser),
        .i_px      (s_axis_tdata[11:0]),
        .i_py      (s_axis_tdata[23:12]),
        .i_take    (w_take),
        .o_valid   (w_s1_valid),
        .o_s1      (w_s1)
    );

    // Classification: one 16x12 multiply and a few compares before the result register.
    tsc_decide u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_s1_valid),
        .i_s1       (w_s1),
        .i_tap_zone (r_tap_zone),
        .i_slope    (r_slope),
        .i_m_ready  (m_axis_tready),
        .o_take     (w_take),
        .o_valid    (m_axis_tvalid),
        .o_gesture  (w_gesture),
        .o_x        (w_x),
        .o_y        (w_y)
    );

    assign m_axis_tdata = {4'd0, w_y, w_x, w_gesture};

endmodule

[rtl/tsc_checker.sv]
// Port-level checker for the touch swipe classifier, bound to the top level.
// Depends on tsc_pkg.
module tsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic w_s_xfer;
    assign w_s_xfer = s_axis_tvalid && s_axis_tready;

    // A result never carries a gesture code beyond the last defined one.
    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= tsc_pkg::G_MAYBE_DOWN)
        else $error("gesture code out of range");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // With the output side open, a transfer shows up with its point once it has passed the front and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer ##1 m_axis_tready) |=>
            (m_axis_tvalid && m_axis_tdata[27:4] == $past(s_axis_tdata, 2)))
        else $error("result missing or point not echoed");

    // A poll that reports a touch never ends a gesture.
    a_touch_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && s_axis_tuser ##1 m_axis_tready) |=>
            (m_axis_tdata[3:0] == tsc_pkg::G_NONE))
        else $error("gesture reported on a touched poll");

endmodule

bind touch_swipe_classifier tsc_checker u_tsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
